@@ design/dmc_pkg.sv @@
package dmc_pkg;

    // Fixed widths of the reported address fields
    localparam int OFFSET_W = 5;
    localparam int BLOCK_W  = 27;
    localparam int LINE_W   = 7;
    localparam int TAG_W    = 20;
    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 32;

    // Decoupling queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic [OFFSET_W-1:0] byte_offset;
        logic [BLOCK_W-1:0]  block_number;
        logic [LINE_W-1:0]   line_index;
        logic [TAG_W-1:0]    tag_value;
    } t_fields;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_CHECK
    } t_back_state;

endpackage

@@ design/dmc_front.sv @@
module dmc_front #(
    parameter int LINE_COUNT  = 128,
    parameter int OFFSET_BITS = 5
) (
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [31:0]                           i_address,
    input  dmc_pkg::t_q_status                    i_q_stat,
    input  logic                                  i_clearing,
    output logic                                  o_push,
    output dmc_pkg::t_fields                      o_fields,
    output logic [$clog2(LINE_COUNT)-1:0]         o_index,
    output logic [31-OFFSET_BITS-$clog2(LINE_COUNT):0] o_tag
);
    import dmc_pkg::*;

    localparam int INDEX_BITS = $clog2(LINE_COUNT);
    localparam int TAG_BITS   = ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam logic [ADDR_W-1:0] OFF_MASK = (ADDR_W'(1) << OFFSET_BITS) - ADDR_W'(1);

    logic [ADDR_W-1:0] w_off32;
    logic [ADDR_W-1:0] w_block32;
    logic [ADDR_W-1:0] w_line32;
    logic [ADDR_W-1:0] w_tag32;

    // Accept only while the queue has room and the tag RAM is not being swept
    assign o_ready = !i_q_stat.full && !i_clearing;
    assign o_push  = i_valid && o_ready;

    assign w_off32   = i_address & OFF_MASK;
    assign w_block32 = i_address >> OFFSET_BITS;
    assign o_index   = w_block32[INDEX_BITS-1:0];
    assign o_tag     = TAG_BITS'(w_block32 >> INDEX_BITS);
    assign w_line32  = ADDR_W'(o_index);
    assign w_tag32   = ADDR_W'(o_tag);

    assign o_fields.byte_offset  = w_off32[OFFSET_W-1:0];
    assign o_fields.block_number = w_block32[BLOCK_W-1:0];
    assign o_fields.line_index   = w_line32[LINE_W-1:0];
    assign o_fields.tag_value    = w_tag32[TAG_W-1:0];

endmodule

@@ design/dmc_fifo.sv @@
module dmc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [WIDTH-1:0]   i_data,
    input  logic               i_pop,
    output logic [WIDTH-1:0]   o_data,
    output dmc_pkg::t_q_status o_stat
);
    import dmc_pkg::*;

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;
    logic [Q_PTR_W:0]   n_count;

    assign o_stat.full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ design/dmc_back.sv @@
module dmc_back #(
    parameter int LINE_COUNT  = 128,
    parameter int OFFSET_BITS = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dmc_pkg::t_q_status                    i_q_stat,
    output logic                                  o_pop,
    input  dmc_pkg::t_fields                      i_fields,
    input  logic [$clog2(LINE_COUNT)-1:0]         i_index,
    input  logic [31-OFFSET_BITS-$clog2(LINE_COUNT):0] i_tag,
    output logic                                  o_clearing,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [4:0]                            o_byte_offset,
    output logic [26:0]                           o_block_number,
    output logic [6:0]                            o_line_index,
    output logic [19:0]                           o_tag_value,
    output logic                                  o_miss,
    output logic                                  o_replacement,
    output logic [19:0]                           o_evicted_tag,
    output logic [31:0]                           o_hit_total,
    output logic [31:0]                           o_miss_total
);
    import dmc_pkg::*;

    localparam int INDEX_BITS = $clog2(LINE_COUNT);
    localparam int TAG_BITS   = ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam logic [INDEX_BITS-1:0] LAST_LINE = INDEX_BITS'(LINE_COUNT - 1);

    // Tag RAM entry: {valid, tag}
    logic [TAG_BITS:0]     r_mem [LINE_COUNT];
    logic [TAG_BITS:0]     r_rd_data;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    logic [TAG_BITS:0]     mem_wdata;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [INDEX_BITS-1:0] r_clr_idx;

    t_fields               r_req_fields;
    logic [INDEX_BITS-1:0] r_req_index;
    logic [TAG_BITS-1:0]   r_req_tag;

    logic                  r_out_valid;
    logic                  load_out;
    logic [COUNT_W-1:0]    r_hit_cnt;
    logic [COUNT_W-1:0]    r_miss_cnt;

    logic                  w_line_valid;
    logic [TAG_BITS-1:0]   w_line_tag;
    logic                  w_hit;
    logic                  w_repl;
    logic [ADDR_W-1:0]     w_old_tag32;

    assign w_line_valid = r_rd_data[TAG_BITS];
    assign w_line_tag   = r_rd_data[TAG_BITS-1:0];
    assign w_hit        = w_line_valid && (w_line_tag == r_req_tag);
    assign w_repl       = w_line_valid && !w_hit;
    assign w_old_tag32  = ADDR_W'(w_line_tag);

    assign o_clearing = (r_state == BK_CLEAR);
    assign o_valid    = r_out_valid;

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_req_index;
        mem_wdata = '0;
        load_out  = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                if (r_clr_idx == LAST_LINE) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                // output slot must be free by the time the check finishes
                if (!i_q_stat.empty && (!r_out_valid || i_ready)) begin
                    o_pop   = 1'b1;
                    n_state = BK_CHECK;
                end
            end
            BK_CHECK: begin
                load_out = 1'b1;
                if (!w_hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = {1'b1, r_req_tag};
                end
                n_state = BK_IDLE;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (load_out) begin
                if (w_hit) begin
                    r_hit_cnt <= r_hit_cnt + 1'b1;
                end else begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_req_fields <= i_fields;
            r_req_index  <= i_index;
            r_req_tag    <= i_tag;
        end
        if (load_out) begin
            o_byte_offset  <= r_req_fields.byte_offset;
            o_block_number <= r_req_fields.block_number;
            o_line_index   <= r_req_fields.line_index;
            o_tag_value    <= r_req_fields.tag_value;
            o_miss         <= !w_hit;
            o_replacement  <= w_repl;
            o_evicted_tag  <= w_repl ? w_old_tag32[TAG_W-1:0] : '0;
            o_hit_total    <= w_hit ? r_hit_cnt + 1'b1 : r_hit_cnt;
            o_miss_total   <= w_hit ? r_miss_cnt : r_miss_cnt + 1'b1;
        end
    end

    // Tag RAM: one write port, registered read addressed by the queue head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[i_index];
    end

endmodule

@@ design/direct_mapped_cache_tag_check.sv @@
// Tag check for a direct-mapped cache of LINE_COUNT lines of 2^OFFSET_BITS
// bytes (LINE_COUNT must be a power of two). Each input beat is one 32-bit
// byte address; each output beat reports its split into byte offset, block
// number, line index and tag, whether it missed, whether a valid line with
// another tag was replaced (and that tag, else 0), and the running hit and
// miss totals after this reference, both wrapping at 32 bits. The front end
// splits the address and drops it into a two-deep queue, so it can take a
// beat in any cycle the queue has room and the tag RAM is not being swept.
// The back end handles one address at a time: in BK_IDLE it pops the queue
// head and starts the registered tag RAM read, in BK_CHECK it does the
// compare, RAM update and load of the output register, and only then goes
// back to BK_IDLE for the next. A new address leaves the queue only when the
// output register is empty or its beat is taken in that same cycle, so a
// stalled output holds the back end and, once the queue is full, o_ready.
// After reset the tag RAM is swept clear, one line per cycle, through all
// LINE_COUNT lines; o_ready stays low until the sweep is done.
module direct_mapped_cache_tag_check #(
    parameter int LINE_COUNT  = 128,
    parameter int OFFSET_BITS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_byte_offset,
    output logic [26:0] o_block_number,
    output logic [6:0]  o_line_index,
    output logic [19:0] o_tag_value,
    output logic        o_miss,
    output logic        o_replacement,
    output logic [19:0] o_evicted_tag,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total
);
    import dmc_pkg::*;

    localparam int INDEX_BITS = $clog2(LINE_COUNT);
    localparam int TAG_BITS   = ADDR_W - OFFSET_BITS - INDEX_BITS;
    localparam int ENTRY_W    = $bits(t_fields) + INDEX_BITS + TAG_BITS;

    t_q_status             q_stat;
    logic                  push;
    logic                  pop;
    logic                  clearing;

    // front -> queue
    t_fields               f_fields;
    logic [INDEX_BITS-1:0] f_index;
    logic [TAG_BITS-1:0]   f_tag;

    // queue head -> back
    logic [ENTRY_W-1:0]    q_head;
    t_fields               b_fields;
    logic [INDEX_BITS-1:0] b_index;
    logic [TAG_BITS-1:0]   b_tag;

    assign {b_fields, b_index, b_tag} = q_head;

    dmc_front #(
        .LINE_COUNT  (LINE_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_address  (i_address),
        .i_q_stat   (q_stat),
        .i_clearing (clearing),
        .o_push     (push),
        .o_fields   (f_fields),
        .o_index    (f_index),
        .o_tag      (f_tag)
    );

    dmc_fifo #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_fields, f_index, f_tag}),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_stat  (q_stat)
    );

    dmc_back #(
        .LINE_COUNT  (LINE_COUNT),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .i_fields       (b_fields),
        .i_index        (b_index),
        .i_tag          (b_tag),
        .o_clearing     (clearing),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_byte_offset  (o_byte_offset),
        .o_block_number (o_block_number),
        .o_line_index   (o_line_index),
        .o_tag_value    (o_tag_value),
        .o_miss         (o_miss),
        .o_replacement  (o_replacement),
        .o_evicted_tag  (o_evicted_tag),
        .o_hit_total    (o_hit_total),
        .o_miss_total   (o_miss_total)
    );

endmodule

@@ design/dmc_checker.sv @@
module dmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [31:0] i_address,
    input logic        o_valid,
    input logic        i_ready,
    input logic [4:0]  o_byte_offset,
    input logic [26:0] o_block_number,
    input logic [6:0]  o_line_index,
    input logic [19:0] o_tag_value,
    input logic        o_miss,
    input logic        o_replacement,
    input logic [19:0] o_evicted_tag,
    input logic [31:0] o_hit_total,
    input logic [31:0] o_miss_total
);

    logic        r_seen;
    logic [31:0] r_prev_hit;
    logic [31:0] r_prev_miss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= 1'b0;
            r_prev_hit  <= '0;
            r_prev_miss <= '0;
        end else if (o_valid && i_ready) begin
            r_seen      <= 1'b1;
            r_prev_hit  <= o_hit_total;
            r_prev_miss <= o_miss_total;
        end
    end

    // a replacement is always a miss
    a_repl_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_replacement |-> o_miss)
        else $error("replacement without miss");

    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_replacement |-> o_evicted_tag == 20'd0)
        else $error("evicted tag nonzero without replacement");

    // exactly one total advances per beat
    a_totals_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && r_seen |->
            (o_miss_total == r_prev_miss + 32'(o_miss)) &&
            (o_hit_total == r_prev_hit + 32'(!o_miss)))
        else $error("running totals out of step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_hit_total) && $stable(o_miss_total))
        else $error("stalled output beat changed");

endmodule

bind direct_mapped_cache_tag_check dmc_checker u_dmc_checker (.*);
